// ===== rtl/core/pnm_hp_pkg.sv =====
// PNM header parser package: widths, character codes, byte classes and the
// shared item type. No dependencies.
package pnm_hp_pkg;

    // Accumulator width; stored header values are FIELD_W bits wide.
    localparam int VALUE_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int CNT_W      = 32;
    localparam int BYTE_W     = 8;

    localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [FIELD_W-1:0] MAGIC_ONE = FIELD_W'(1);

    typedef enum logic [2:0] {
        CLS_HASH,
        CLS_BLANK,
        CLS_EOL,
        CLS_DIGIT,
        CLS_OTHER
    } byte_class_t;

    // One registered input item.
    typedef struct packed {
        logic              start_file;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    function automatic byte_class_t classify(input logic [BYTE_W-1:0] b);
        byte_class_t cls;
        if (b == CHAR_HASH)
            cls = CLS_HASH;
        else if (b inside {CHAR_SPACE, CHAR_TAB})
            cls = CLS_BLANK;
        else if (b inside {CHAR_CR, CHAR_LF})
            cls = CLS_EOL;
        else if (b inside {[CHAR_ZERO:CHAR_NINE]})
            cls = CLS_DIGIT;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

endpackage

// ===== rtl/core/pnm_hp_in_stage.sv =====
// Input register stage of the PNM header parser: holds one item until the
// parser core takes it. Depends on pnm_hp_pkg.
module pnm_hp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              start_file,
    input  logic [7:0]        data_byte,
    output logic              stage_valid,
    input  logic              stage_take,
    output pnm_hp_pkg::item_t stage_item
);
    import pnm_hp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held item leaves this cycle.
    assign item_ready = !valid_reg || stage_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
            valid_next = item_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
            item_reg <= '{start_file: start_file, data_byte: data_byte};
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== rtl/core/pnm_hp_core.sv =====
// Parser core: header state and result register, updated once per item.
// Depends on pnm_hp_pkg.
module pnm_hp_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          stage_valid,
    output logic                          stage_take,
    input  pnm_hp_pkg::item_t             stage_item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          header_done,
    output logic [pnm_hp_pkg::FIELD_W-1:0] magic_number,
    output logic [pnm_hp_pkg::FIELD_W-1:0] image_width,
    output logic [pnm_hp_pkg::FIELD_W-1:0] image_height,
    output logic [pnm_hp_pkg::FIELD_W-1:0] max_grey,
    output logic [pnm_hp_pkg::CNT_W-1:0]   bytes_used
);
    import pnm_hp_pkg::*;

    localparam int MUL_W = VALUE_BITS + 4;
    localparam logic [MUL_W-1:0] ACC_MAX_W = MUL_W'({VALUE_BITS{1'b1}});

    logic                  valid_reg, valid_next;
    logic                  done_reg, done_next;
    logic                  comment_reg, comment_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [FIELD_W-1:0]    magic_reg, magic_next;
    logic [FIELD_W-1:0]    width_reg, width_next;
    logic [FIELD_W-1:0]    height_reg, height_next;
    logic [FIELD_W-1:0]    grey_reg, grey_next;

    // State as seen by this item, after an optional start-of-file clear.
    logic                  done_b, comment_b;
    logic [VALUE_BITS-1:0] acc_b;
    logic [CNT_W-1:0]      count_b;
    logic [FIELD_W-1:0]    magic_b, width_b, height_b, grey_b;

    byte_class_t           cls;
    logic [MUL_W-1:0]      acc_x10;
    logic [MUL_W-1:0]      digit_sum;
    logic [VALUE_BITS+FIELD_W-1:0] acc_ext;
    logic [FIELD_W-1:0]    val;
    logic                  finish;

    assign stage_take = stage_valid && (!valid_reg || result_ready);

    always_comb
    begin
        if (stage_item.start_file)
        begin
            done_b    = 1'b0;
            comment_b = 1'b0;
            acc_b     = '0;
            count_b   = '0;
            magic_b   = '0;
            width_b   = '0;
            height_b  = '0;
            grey_b    = '0;
        end
        else
        begin
            done_b    = done_reg;
            comment_b = comment_reg;
            acc_b     = acc_reg;
            count_b   = count_reg;
            magic_b   = magic_reg;
            width_b   = width_reg;
            height_b  = height_reg;
            grey_b    = grey_reg;
        end

        cls       = classify(stage_item.data_byte);
        acc_x10   = (MUL_W'(acc_b) << 3) + (MUL_W'(acc_b) << 1);
        digit_sum = acc_x10 + MUL_W'(stage_item.data_byte[3:0]);
        acc_ext   = {{FIELD_W{1'b0}}, acc_b};
        val       = acc_ext[FIELD_W-1:0];
        finish    = !done_b && (cls inside {CLS_HASH, CLS_BLANK, CLS_EOL});

        done_next    = done_b;
        comment_next = comment_b;
        acc_next     = acc_b;
        count_next   = count_b;
        magic_next   = magic_b;
        width_next   = width_b;
        height_next  = height_b;
        grey_next    = grey_b;

        if (finish)
        begin
            acc_next = '0;
            // Fill the first empty slot with a finished nonzero number.
            if (!comment_b && (acc_b != '0))
            begin
                if (magic_b == '0)
                    magic_next = val;
                else if (width_b == '0)
                    width_next = val;
                else if (height_b == '0)
                begin
                    height_next = val;
                    done_next   = (magic_b == MAGIC_ONE);
                end
                else if (grey_b == '0)
                begin
                    grey_next = val;
                    done_next = (magic_b > MAGIC_ONE);
                end
            end
        end

        if (!done_b)
        begin
            case (cls)
                CLS_HASH:  comment_next = 1'b1;
                CLS_EOL:   comment_next = 1'b0;
                CLS_DIGIT:
                begin
                    if (!comment_b)
                        acc_next = (digit_sum > ACC_MAX_W) ? {VALUE_BITS{1'b1}}
                                                           : digit_sum[VALUE_BITS-1:0];
                end
                default:   comment_next = comment_b;
            endcase
            if (count_b != {CNT_W{1'b1}})
                count_next = count_b + CNT_W'(1);
        end

        valid_next = valid_reg;
        if (stage_take)
            valid_next = 1'b1;
        else if (result_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            done_reg    <= 1'b0;
            comment_reg <= 1'b0;
            acc_reg     <= '0;
            count_reg   <= '0;
            magic_reg   <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            grey_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (stage_take)
            begin
                done_reg    <= done_next;
                comment_reg <= comment_next;
                acc_reg     <= acc_next;
                count_reg   <= count_next;
                magic_reg   <= magic_next;
                width_reg   <= width_next;
                height_reg  <= height_next;
                grey_reg    <= grey_next;
            end
        end
    end

    // The header state after each item is the result itself.
    assign result_valid = valid_reg;
    assign header_done  = done_reg;
    assign magic_number = magic_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;
    assign max_grey     = grey_reg;
    assign bytes_used   = count_reg;

endmodule

// ===== rtl/core/pnm_header_parser_unit.sv =====
// PNM header parser top level: input register stage plus parser core.
// Depends on pnm_hp_pkg, pnm_hp_in_stage and pnm_hp_core.
//
// Feed the file one byte per item, with start_file set on the first byte of
// each file. Every item yields one result: the header values parsed so far,
// the done flag and the count of bytes consumed up to header completion.
// Throughput is one item per cycle unless result_ready stalls the flow. An
// accepted item loads the input register, then the state/result register.
// The decimal accumulator update (multiply by ten plus digit, saturating)
// lies on the path between those registers. Result ready propagates back to
// item ready combinationally through the two register stages.
module pnm_header_parser_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          start_file,
    input  logic [7:0]                    data_byte,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic                          header_done,
    output logic [pnm_hp_pkg::FIELD_W-1:0] magic_number,
    output logic [pnm_hp_pkg::FIELD_W-1:0] image_width,
    output logic [pnm_hp_pkg::FIELD_W-1:0] image_height,
    output logic [pnm_hp_pkg::FIELD_W-1:0] max_grey,
    output logic [pnm_hp_pkg::CNT_W-1:0]   bytes_used
);
    import pnm_hp_pkg::*;

    logic  stage_valid;
    logic  stage_take;
    item_t stage_item;

    pnm_hp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .start_file  (start_file),
        .data_byte   (data_byte),
        .stage_valid (stage_valid),
        .stage_take  (stage_take),
        .stage_item  (stage_item)
    );

    pnm_hp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_valid  (stage_valid),
        .stage_take   (stage_take),
        .stage_item   (stage_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .header_done  (header_done),
        .magic_number (magic_number),
        .image_width  (image_width),
        .image_height (image_height),
        .max_grey     (max_grey),
        .bytes_used   (bytes_used)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for pnm_header_parser_unit: feeds PNM-style byte streams and checks
// every result against a behavioral header parser kept in the bench.
// Depends on pnm_hp_pkg and the pnm_header_parser_unit RTL.
module tb_top;
    import pnm_hp_pkg::*;

    localparam logic [63:0] ACC_MAX = (64'd1 << VALUE_BITS) - 64'd1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic               done;
        logic [FIELD_W-1:0] magic;
        logic [FIELD_W-1:0] width;
        logic [FIELD_W-1:0] height;
        logic [FIELD_W-1:0] grey;
        logic [CNT_W-1:0]   used;
    } header_state_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    logic               start_file;
    logic [7:0]         data_byte;
    logic               result_valid;
    logic               result_ready;
    logic               header_done;
    logic [FIELD_W-1:0] magic_number;
    logic [FIELD_W-1:0] image_width;
    logic [FIELD_W-1:0] image_height;
    logic [FIELD_W-1:0] max_grey;
    logic [CNT_W-1:0]   bytes_used;

    // Header parser state as the bench sees it
    logic [FIELD_W-1:0] hp_magic;
    logic [FIELD_W-1:0] hp_width;
    logic [FIELD_W-1:0] hp_height;
    logic [FIELD_W-1:0] hp_grey;
    logic               hp_done;
    logic               hp_comment;
    logic [63:0]        hp_acc;
    logic [CNT_W-1:0]   hp_count;

    header_state_t pending_headers[$];
    logic [7:0]    file_bytes[$];

    int unsigned send_gap_max = 0;
    int unsigned recv_gap_max = 0;
    int unsigned sent_items   = 0;
    int unsigned err_count    = 0;

    pnm_header_parser_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .start_file   (start_file),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .header_done  (header_done),
        .magic_number (magic_number),
        .image_width  (image_width),
        .image_height (image_height),
        .max_grey     (max_grey),
        .bytes_used   (bytes_used)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic clear_header_state();
        hp_magic   = '0;
        hp_width   = '0;
        hp_height  = '0;
        hp_grey    = '0;
        hp_done    = 1'b0;
        hp_comment = 1'b0;
        hp_acc     = '0;
        hp_count   = '0;
    endtask

    // Close the current number: a nonzero value outside a comment fills the
    // next empty header slot.
    task automatic close_number();
        logic [FIELD_W-1:0] val;
        val = hp_acc[FIELD_W-1:0];
        if (!hp_comment && hp_acc != 0)
        begin
            if (hp_magic == 0)
                hp_magic = val;
            else if (hp_width == 0)
                hp_width = val;
            else if (hp_height == 0)
            begin
                hp_height = val;
                hp_done   = (hp_magic == MAGIC_ONE);
            end
            else if (hp_grey == 0)
            begin
                hp_grey = val;
                hp_done = (hp_magic > MAGIC_ONE);
            end
        end
        hp_acc = '0;
    endtask

    task automatic advance_header_model(input logic sf, input logic [7:0] b);
        header_state_t r;
        logic [63:0]   n;
        if (sf)
            clear_header_state();
        if (!hp_done)
        begin
            if (b == CHAR_HASH)
            begin
                close_number();
                hp_comment = 1'b1;
            end
            else if (b == CHAR_SPACE || b == CHAR_TAB)
                close_number();
            else if (b == CHAR_CR || b == CHAR_LF)
            begin
                close_number();
                hp_comment = 1'b0;
            end
            else if (!hp_comment && b >= CHAR_ZERO && b <= CHAR_NINE)
            begin
                n      = hp_acc * 64'd10 + {56'd0, b} - {56'd0, CHAR_ZERO};
                hp_acc = (n > ACC_MAX) ? ACC_MAX : n;
            end
            if (hp_count != CNT_MAX)
                hp_count++;
        end
        r.done   = hp_done;
        r.magic  = hp_magic;
        r.width  = hp_width;
        r.height = hp_height;
        r.grey   = hp_grey;
        r.used   = hp_count;
        pending_headers.push_back(r);
    endtask

    // Drive one item and hold it until accepted. Ready is sampled at the
    // falling edge, where it already holds its value for the next rising edge.
    task automatic send_byte(input logic sf, input logic [7:0] b);
        int unsigned gap;
        logic        ok;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        start_file <= sf;
        data_byte  <= b;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = item_ready;
            @(posedge clk);
        end
        sent_items++;
        advance_header_model(sf, b);
    endtask

    task automatic send_file(input logic first_start);
        foreach (file_bytes[i])
            send_byte(first_start && i == 0, file_bytes[i]);
        file_bytes.delete();
    endtask

    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_headers.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_byte(input logic [7:0] b);
        file_bytes.push_back(b);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endtask

    task automatic add_number(input int unsigned n);
        if ($urandom_range(0, 7) == 0)
            add_byte(CHAR_ZERO);
        add_text($sformatf("%0d", n));
    endtask

    function automatic int unsigned pick_value();
        int unsigned v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = $urandom_range(65530, 70000);
            2:       v = $urandom_range(0, 99999);
            default: v = $urandom_range(1, 999);
        endcase
        return v;
    endfunction

    task automatic add_separator();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            2: add_byte(CHAR_TAB);
            3: add_byte(CHAR_LF);
            4:
            begin
                add_byte(CHAR_CR);
                add_byte(CHAR_LF);
            end
            5:
            begin
                add_byte(CHAR_SPACE);
                add_byte(CHAR_TAB);
                add_byte(CHAR_SPACE);
            end
            6:
            begin
                add_byte(CHAR_HASH);
                repeat ($urandom_range(0, 6))
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CHAR_CR || b == CHAR_LF)
                        b = CHAR_HASH;
                    add_byte(b);
                end
                add_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end
            7: add_byte(CHAR_CR);
            // junk byte: digits on both sides join into one number
            8: add_byte($urandom_range(0, 1) ? 8'h78 : 8'($urandom_range(128, 255)));
            default: add_byte(CHAR_SPACE);
        endcase
    endtask

    // Build a header with the given number of fields after the magic.
    task automatic build_header(input int unsigned fields);
        int unsigned magic;
        if ($urandom_range(0, 4) == 0)
            add_separator();
        if ($urandom_range(0, 7) != 0)
            add_text("P");
        case ($urandom_range(0, 5))
            0:       magic = 1;
            4:       magic = 0;
            5:       magic = pick_value();
            default: magic = $urandom_range(2, 6);
        endcase
        add_number(magic);
        repeat (fields)
        begin
            add_separator();
            add_number(pick_value());
        end
        add_separator();
        repeat ($urandom_range(0, 3))
            add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t ERROR %s: expected %0d, actual %0d", $time, name, exp, act);
            err_count++;
        end
    endtask

    // Result side: random stall before each result, then hold ready until taken
    initial
    begin
        logic        ok;
        int unsigned gap;
        forever
        begin
            gap = $urandom_range(0, recv_gap_max);
            if (gap != 0)
            begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            ok = 1'b0;
            while (!ok)
            begin
                @(negedge clk);
                ok = rst_n && result_valid;
                @(posedge clk);
            end
        end
    end

    always @(negedge clk)
    begin
        header_state_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_headers.size() == 0)
            begin
                $display("%0t ERROR unexpected result: done %0d magic %0d width %0d",
                         $time, header_done, magic_number, image_width);
                err_count++;
            end
            else
            begin
                e = pending_headers.pop_front();
                check_field("header_done", 32'(e.done), 32'(header_done));
                check_field("magic_number", 32'(e.magic), 32'(magic_number));
                check_field("image_width", 32'(e.width), 32'(image_width));
                check_field("image_height", 32'(e.height), 32'(image_height));
                check_field("max_grey", 32'(e.grey), 32'(max_grey));
                check_field("bytes_used", e.used, bytes_used);
            end
        end
    end

    // Magic 1 ends at the height; the byte after that is ignored.
    task automatic test_magic_one_header();
        send_gap_max = 0;
        recv_gap_max = 0;
        add_text("P1 2 3");
        add_byte(CHAR_LF);
        add_text("7");
        send_file(1'b1);
    endtask

    // Comment with a tab inside, a zero value dropped, a letter joining digits.
    task automatic test_comment_zero_and_junk();
        send_gap_max = 8;
        recv_gap_max = 8;
        add_text("5");
        add_byte(CHAR_HASH);
        add_text("9");
        add_byte(CHAR_TAB);
        add_byte(CHAR_LF);
        add_text("0 4x5");
        add_byte(CHAR_TAB);
        add_text("6 7 ");
        send_file(1'b1);
    endtask

    // Saturating accumulator and the extreme byte values.
    task automatic test_saturation_and_extremes();
        add_text("9");
        add_byte(8'hFF);
        add_text("9999");
        add_byte(CHAR_CR);
        add_text("7");
        add_byte(8'h00);
        add_text("0");
        add_byte(CHAR_LF);
        send_file(1'b1);
    endtask

    task automatic test_pause_until_drained();
        hold_until_drained();
        build_header(3);
        send_file(1'b1);
    endtask

    task automatic test_random_streams();
        while (sent_items < 500)
        begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            case ($urandom_range(0, 9))
                7:
                begin
                    build_header($urandom_range(0, 2));
                    send_file(1'b1);
                end
                8:
                begin
                    repeat ($urandom_range(5, 30))
                        send_byte($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
                end
                9: hold_until_drained();
                default:
                begin
                    build_header(3);
                    send_file($urandom_range(0, 9) != 0);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        start_file <= 1'b0;
        data_byte  <= 8'h00;
        clear_header_state();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_magic_one_header();
        test_comment_zero_and_junk();
        test_saturation_and_extremes();
        test_pause_until_drained();
        test_random_streams();

        hold_until_drained();
        repeat (6) @(posedge clk);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== pnm_header_parser_unit.f =====
rtl/core/pnm_hp_pkg.sv
rtl/core/pnm_hp_in_stage.sv
rtl/core/pnm_hp_core.sv
rtl/core/pnm_header_parser_unit.sv
tb/sv/tb_top.sv
